>>> rtl/fscc_pkg.sv
// Package for the framed stepper command controller.
// Holds field widths, operation codes, the result record and the phase table.
// Has no dependencies; used by framed_stepper_command_controller.
package fscc_pkg;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int COIL_W  = 4;
    localparam int POS_W   = 3;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 3;

    localparam logic [OP_W-1:0] OP_RX       = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
    localparam logic [OP_W-1:0] OP_CHOP_ON  = 2'd2;
    localparam logic [OP_W-1:0] OP_CHOP_OFF = 2'd3;

    localparam logic [BYTE_W-1:0] START_MARK = 8'hFF;
    localparam logic [CNT_W-1:0]  LAST_BYTE  = 3'd7;
    localparam int FRAME_STORE_DEPTH = 7;

    localparam logic [BYTE_W-1:0] CMD_STOP   = 8'd8;
    localparam logic [BYTE_W-1:0] CMD_CLOSED = 8'd9;
    localparam logic [BYTE_W-1:0] CMD_SINGLE_MAX = 8'd3;
    localparam logic [BYTE_W-1:0] CMD_CONT_MAX   = 8'd7;
    localparam logic [BYTE_W-1:0] CMD_WHOLE_SINGLE_MAX = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_WHOLE_CONT_MAX   = 8'd5;

    typedef struct packed {
        logic [COIL_W-1:0] coil_drive;
        logic [POS_W-1:0]  step_position;
        logic [WORD_W-1:0] step_period;
        logic [WORD_W-1:0] dc_value;
        logic [BYTE_W-1:0] dc_command;
        logic              frame_done;
        logic              continuous_on;
    } res_t;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [POS_W-1:0] pos);
        logic [COIL_W-1:0] pat;
        case (pos)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1010;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b0101;
            3'd6:    pat = 4'b0001;
            3'd7:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
                                                  input logic whole,
                                                  input logic fwd);
        logic [POS_W:0] sum;
        logic [POS_W:0] dec;
        logic [POS_W-1:0] res;
        sum = {1'b0, pos} + 4'd1 + {3'd0, whole};
        dec = {1'b0, pos} - 4'd1 - {3'd0, whole};
        if (fwd)
        begin
            res = sum[POS_W] ? 3'd0 : sum[POS_W-1:0];
        end
        else
        begin
            if (dec[POS_W])
            begin
                res = whole ? 3'd6 : 3'd7;
            end
            else
            begin
                res = dec[POS_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/framed_stepper_command_controller.sv
// Framed stepper command controller: frame assembly, half-step sequencer, coil gating.
// Depends on fscc_pkg for widths, operation codes, the result record and the phase table.
//
//  Channel | Handshake           | Beat contents
//  --------+---------------------+------------------------------------------------------
//  in      | in_valid, in_ready  | operation, rx_byte
//  out     | out_valid,out_ready | coil_drive, step_position, step_period, dc_value,
//          |                     | dc_command, frame_done, continuous_on
//
// The result of each input beat is registered into the output buffer.
// One beat per cycle is sustained while the output side keeps taking results.
// Results wait in a two-entry output buffer; in_ready drops only when both entries are full.
// Reset is asynchronous and active low.
module framed_stepper_command_controller
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fscc_pkg::OP_W-1:0]    operation,
    input  logic [fscc_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fscc_pkg::COIL_W-1:0]  coil_drive,
    output logic [fscc_pkg::POS_W-1:0]   step_position,
    output logic [fscc_pkg::WORD_W-1:0]  step_period,
    output logic [fscc_pkg::WORD_W-1:0]  dc_value,
    output logic [fscc_pkg::BYTE_W-1:0]  dc_command,
    output logic                         frame_done,
    output logic                         continuous_on
);
    import fscc_pkg::*;

    logic [BYTE_W-1:0] frame_bytes_reg [FRAME_STORE_DEPTH];
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [POS_W-1:0]  phase_reg, phase_next;
    logic              whole_reg, whole_next;
    logic              cw_reg, cw_next;
    logic              cont_reg, cont_next;
    logic              stop_reg, stop_next;
    logic              closed_reg, closed_next;
    logic [WORD_W-1:0] period_reg, period_next;
    logic [WORD_W-1:0] dcval_reg, dcval_next;
    logic [BYTE_W-1:0] dccmd_reg, dccmd_next;
    logic [COIL_W-1:0] coil_reg, coil_next;
    logic              done_next;
    logic              store_we;

    logic [BYTE_W-1:0] cmd0, cmd1, sh, sl, dh, dl;
    logic              whole_frame;
    logic [POS_W-1:0]  phase_frame;

    logic [1:0]        count_reg;
    res_t              head_reg, skid_reg;
    res_t              res_new;
    logic              push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign pop      = out_valid && out_ready;

    assign cmd0 = frame_bytes_reg[1];
    assign cmd1 = frame_bytes_reg[2];
    assign sh   = rx_byte[3] ? START_MARK : frame_bytes_reg[3];
    assign sl   = rx_byte[2] ? START_MARK : frame_bytes_reg[4];
    assign dh   = rx_byte[1] ? START_MARK : frame_bytes_reg[5];
    assign dl   = rx_byte[0] ? START_MARK : frame_bytes_reg[6];

    assign whole_frame = (cmd0 <= CMD_SINGLE_MAX) ? (cmd0 <= CMD_WHOLE_SINGLE_MAX) : whole_reg;
    assign phase_frame = step_pos(phase_reg, whole_frame, ~cmd0[0]);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        phase_next      = phase_reg;
        whole_next      = whole_reg;
        cw_next         = cw_reg;
        cont_next       = cont_reg;
        stop_next       = stop_reg;
        closed_next     = closed_reg;
        period_next     = period_reg;
        dcval_next      = dcval_reg;
        dccmd_next      = dccmd_reg;
        coil_next       = coil_reg;
        done_next       = 1'b0;
        store_we        = 1'b0;
        case (operation)
            OP_RX:
            begin
                if (byte_count_reg == 3'd0)
                begin
                    if (rx_byte == START_MARK)
                    begin
                        store_we        = 1'b1;
                        byte_count_next = 3'd1;
                    end
                end
                else if (byte_count_reg != LAST_BYTE)
                begin
                    store_we        = 1'b1;
                    byte_count_next = byte_count_reg + 3'd1;
                end
                else
                begin
                    byte_count_next = 3'd0;
                    done_next       = 1'b1;
                    if (!closed_reg)
                    begin
                        period_next = {sh, sl};
                    end
                    dcval_next = {dh, dl};
                    dccmd_next = cmd1;
                    stop_next  = (cmd0 == CMD_STOP);
                    if (cmd0 <= CMD_SINGLE_MAX)
                    begin
                        closed_next = 1'b0;
                        whole_next  = whole_frame;
                        phase_next  = phase_frame;
                        cont_next   = 1'b0;
                    end
                    else if (cmd0 <= CMD_CONT_MAX)
                    begin
                        closed_next = 1'b0;
                        whole_next  = (cmd0 <= CMD_WHOLE_CONT_MAX);
                        cw_next     = ~cmd0[0];
                        cont_next   = 1'b1;
                    end
                    else if (cmd0 == CMD_STOP)
                    begin
                        closed_next = 1'b0;
                    end
                    else if (cmd0 == CMD_CLOSED)
                    begin
                        closed_next = 1'b1;
                    end
                    coil_next = coil_pattern(phase_next);
                end
            end
            OP_TICK:
            begin
                if (cont_reg && !stop_reg)
                begin
                    phase_next = step_pos(phase_reg, whole_reg, cw_reg);
                end
            end
            OP_CHOP_ON:
            begin
                coil_next = coil_pattern(phase_reg);
            end
            OP_CHOP_OFF:
            begin
                coil_next = '0;
            end
            default:
            begin
                coil_next = coil_reg;
            end
        endcase
    end

    always_comb
    begin
        res_new.coil_drive    = coil_next;
        res_new.step_position = phase_next;
        res_new.step_period   = period_next;
        res_new.dc_value      = dcval_next;
        res_new.dc_command    = dccmd_next;
        res_new.frame_done    = done_next;
        res_new.continuous_on = cont_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && store_we)
        begin
            frame_bytes_reg[byte_count_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            phase_reg      <= '0;
            whole_reg      <= 1'b1;
            cw_reg         <= 1'b1;
            cont_reg       <= 1'b0;
            stop_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            period_reg     <= '0;
            dcval_reg      <= '0;
            dccmd_reg      <= '0;
            coil_reg       <= '0;
        end
        else if (push)
        begin
            byte_count_reg <= byte_count_next;
            phase_reg      <= phase_next;
            whole_reg      <= whole_next;
            cw_reg         <= cw_next;
            cont_reg       <= cont_next;
            stop_reg       <= stop_next;
            closed_reg     <= closed_next;
            period_reg     <= period_next;
            dcval_reg      <= dcval_next;
            dccmd_reg      <= dccmd_next;
            coil_reg       <= coil_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= skid_reg;
                skid_reg <= res_new;
            end
            else
            begin
                head_reg <= res_new;
            end
        end
        else if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= res_new;
            end
            else
            begin
                skid_reg <= res_new;
            end
        end
    end

    assign coil_drive    = head_reg.coil_drive;
    assign step_position = head_reg.step_position;
    assign step_period   = head_reg.step_period;
    assign dc_value      = head_reg.dc_value;
    assign dc_command    = head_reg.dc_command;
    assign frame_done    = head_reg.frame_done;
    assign continuous_on = head_reg.continuous_on;

    // The output buffer holds at most two results.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // Events other than received bytes never move the frame position.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        push && operation != OP_RX |=> $stable(byte_count_reg))
        else $error("frame position moved on a non-byte event");

    // A chop-off beat leaves the coils released.
    a_chop_off: assert property (@(posedge clk) disable iff (!rst_n)
        push && operation == OP_CHOP_OFF |=> coil_reg == '0)
        else $error("coils not released after chop off");

    // A tick with stepping disabled or stopped leaves the position alone.
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && operation == OP_TICK && (!cont_reg || stop_reg) |=> $stable(phase_reg))
        else $error("position moved on an idle tick");

    // A completed frame always returns the assembler to waiting for a start byte.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && done_next |=> byte_count_reg == 3'd0)
        else $error("frame assembler not reset after a frame");

endmodule
